### sv/ljpe_pkg.sv
`timescale 1ns / 1ps
// Package for the Lennard-Jones pair evaluator: word types, mode and status codes,
// and the per-mode power and coefficient tables. No dependencies.
package ljpe_pkg;

  localparam logic [1:0] MODE_ENERGY = 2'd0;
  localparam logic [1:0] MODE_FORCE  = 2'd1;
  localparam logic [1:0] MODE_STIFF  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam int unsigned NUM_POW = 14;

  typedef struct packed {
    logic [31:0] distance;
    logic [1:0]  mode;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } out_word_t;

  // Side information that rides along with every word in flight.
  typedef struct packed {
    logic [1:0] mode;
    logic       zero;
  } side_t;

  function automatic logic [3:0] lo_pow(input logic [1:0] mode);
    case (mode)
      MODE_ENERGY: lo_pow = 4'd6;
      MODE_FORCE:  lo_pow = 4'd7;
      MODE_STIFF:  lo_pow = 4'd8;
      default:     lo_pow = 4'd0;
    endcase
  endfunction

  function automatic logic [3:0] hi_pow(input logic [1:0] mode);
    case (mode)
      MODE_ENERGY: hi_pow = 4'd12;
      MODE_FORCE:  hi_pow = 4'd13;
      MODE_STIFF:  hi_pow = 4'd14;
      default:     hi_pow = 4'd0;
    endcase
  endfunction

  function automatic logic [6:0] hi_coef(input logic [1:0] mode);
    case (mode)
      MODE_ENERGY: hi_coef = 7'd1;
      MODE_FORCE:  hi_coef = 7'd6;
      MODE_STIFF:  hi_coef = 7'd78;
      default:     hi_coef = 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] lo_coef(input logic [1:0] mode);
    case (mode)
      MODE_ENERGY: lo_coef = 7'd2;
      MODE_FORCE:  lo_coef = 7'd6;
      MODE_STIFF:  lo_coef = 7'd42;
      default:     lo_coef = 7'd0;
    endcase
  endfunction

endpackage

### sv/ljpe_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider forming q = floor(length_scale * 2^F / distance),
// one quotient bit per register stage. Depends on ljpe_pkg.
module ljpe_div import ljpe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  side_t                   in_side,
  input  logic [31:0]             numer_hi,
  input  logic [31:0]             divisor,
  output logic                    out_vld,
  output side_t                   out_side,
  output logic [32+FRAC_BITS-1:0] quot
);

  localparam int QW = 32 + FRAC_BITS;

  logic          vld_r  [QW];
  side_t         side_r [QW];
  logic [31:0]   rem_r  [QW];
  logic [QW-1:0] num_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [31:0]   dsr_r  [QW];

  genvar s;
  generate
    for (s = 0; s < QW; s++) begin : g_stage
      logic          vld_i;
      side_t         side_i;
      logic [31:0]   rem_i;
      logic [QW-1:0] num_i;
      logic [QW-1:0] quo_i;
      logic [31:0]   dsr_i;
      logic [32:0]   trial;
      logic          take;

      if (s == 0) begin : g_first
        assign vld_i  = in_vld;
        assign side_i = in_side;
        assign rem_i  = '0;
        assign num_i  = {numer_hi, {FRAC_BITS{1'b0}}};
        assign quo_i  = '0;
        assign dsr_i  = divisor;
      end else begin : g_next
        assign vld_i  = vld_r[s-1];
        assign side_i = side_r[s-1];
        assign rem_i  = rem_r[s-1];
        assign num_i  = num_r[s-1];
        assign quo_i  = quo_r[s-1];
        assign dsr_i  = dsr_r[s-1];
      end

      assign trial = {rem_i, num_i[QW-1-s]};
      assign take  = (trial >= {1'b0, dsr_i});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (en) begin
          vld_r[s] <= vld_i;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side_r[s] <= side_i;
          rem_r[s]  <= take ? 32'(trial - {1'b0, dsr_i}) : trial[31:0];
          num_r[s]  <= num_i;
          quo_r[s]  <= {quo_i[QW-2:0], take};
          dsr_r[s]  <= dsr_i;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[QW-1];
  assign out_side = side_r[QW-1];
  assign quot     = quo_r[QW-1];

endmodule

### sv/ljpe_pow.sv
`timescale 1ns / 1ps
// One power step p(K) = floor(p(K-1) * q / 2^F) in two register stages: limb
// partial products, then sum, scale and cap check. Depends on ljpe_pkg.
module ljpe_pow import ljpe_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int K         = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  side_t                   in_side,
  input  logic [32+FRAC_BITS-1:0] in_q,
  input  logic [66+FRAC_BITS-1:0] in_p,
  input  logic                    in_big,
  input  logic [66+FRAC_BITS-1:0] in_plo,
  input  logic [66+FRAC_BITS-1:0] in_phi,
  input  logic                    in_bighi,
  output logic                    out_vld,
  output side_t                   out_side,
  output logic [32+FRAC_BITS-1:0] out_q,
  output logic [66+FRAC_BITS-1:0] out_p,
  output logic                    out_big,
  output logic [66+FRAC_BITS-1:0] out_plo,
  output logic [66+FRAC_BITS-1:0] out_phi,
  output logic                    out_bighi
);

  localparam int QW  = 32 + FRAC_BITS;
  localparam int PW  = 66 + FRAC_BITS;
  localparam int NL  = (PW + 31) / 32;
  localparam int NLQ = (QW + 31) / 32;
  localparam int NPP = NL * NLQ;
  localparam int SW  = (NL + NLQ) * 32;

  logic [NL*32-1:0]  p_ext;
  logic [NLQ*32-1:0] q_ext;

  // Stage A: partial products.
  logic          a_vld_r;
  side_t         a_side_r;
  logic [QW-1:0] a_q_r;
  logic          a_big_r;
  logic [PW-1:0] a_plo_r;
  logic [PW-1:0] a_phi_r;
  logic          a_bighi_r;
  logic [63:0]   a_pp_r [NPP];

  assign p_ext = (NL*32)'(in_p);
  assign q_ext = (NLQ*32)'(in_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r  <= in_side;
      a_q_r     <= in_q;
      a_big_r   <= in_big;
      a_plo_r   <= in_plo;
      a_phi_r   <= in_phi;
      a_bighi_r <= in_bighi;
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NLQ; j++) begin
          a_pp_r[i*NLQ+j] <= 64'(p_ext[i*32 +: 32]) * 64'(q_ext[j*32 +: 32]);
        end
      end
    end
  end

  // Stage B: sum, scale and cap check.
  logic [SW-1:0] sum;
  logic [PW-1:0] p_nxt;
  logic          big_nxt;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NL; i++) begin
      for (int j = 0; j < NLQ; j++) begin
        sum = sum + (SW'(a_pp_r[i*NLQ+j]) << (32*(i+j)));
      end
    end
    p_nxt   = PW'(sum >> FRAC_BITS);
    big_nxt = a_big_r || ((sum >> (66 + 2*FRAC_BITS)) != '0);
  end

  logic          b_vld_r;
  side_t         b_side_r;
  logic [QW-1:0] b_q_r;
  logic [PW-1:0] b_p_r;
  logic          b_big_r;
  logic [PW-1:0] b_plo_r;
  logic [PW-1:0] b_phi_r;
  logic          b_bighi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side_r  <= a_side_r;
      b_q_r     <= a_q_r;
      b_p_r     <= p_nxt;
      b_big_r   <= big_nxt;
      b_plo_r   <= (lo_pow(a_side_r.mode) == 4'(K)) ? p_nxt : a_plo_r;
      b_phi_r   <= (hi_pow(a_side_r.mode) == 4'(K)) ? p_nxt : a_phi_r;
      b_bighi_r <= (hi_pow(a_side_r.mode) == 4'(K)) ? big_nxt : a_bighi_r;
    end
  end

  assign out_vld   = b_vld_r;
  assign out_side  = b_side_r;
  assign out_q     = b_q_r;
  assign out_p     = b_p_r;
  assign out_big   = b_big_r;
  assign out_plo   = b_plo_r;
  assign out_phi   = b_phi_r;
  assign out_bighi = b_bighi_r;

endmodule

### sv/ljpe_out.sv
`timescale 1ns / 1ps
// Result stages: coefficient difference, scaling by the well depth, rounding
// toward zero and saturation, ending in the output register. Depends on ljpe_pkg.
module ljpe_out import ljpe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic [31:0]             well_depth,
  input  logic                    in_vld,
  input  side_t                   in_side,
  input  logic [66+FRAC_BITS-1:0] in_plo,
  input  logic [66+FRAC_BITS-1:0] in_phi,
  input  logic                    in_bighi,
  output logic                    out_vld,
  output out_word_t               out_word
);

  localparam int PW = 66 + FRAC_BITS;
  localparam int AW = PW + 7;

  // Stage 1: magnitude and sign of ch*phi - cl*plo.
  logic [AW-1:0] a_w;
  logic [AW-1:0] b_w;
  logic [AW-1:0] mag_w;
  logic          a_ge;

  assign a_w   = AW'(in_phi) * AW'(hi_coef(in_side.mode));
  assign b_w   = AW'(in_plo) * AW'(lo_coef(in_side.mode));
  assign a_ge  = (a_w >= b_w);
  assign mag_w = a_ge ? (a_w - b_w) : (b_w - a_w);

  logic        s1_vld_r;
  logic [95:0] s1_mag_r;
  logic        s1_neg_r;
  logic        s1_sat_r;
  logic        s1_zero_r;
  logic        s1_kill_r;
  logic        s1_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_r  <= 96'(mag_w);
      s1_neg_r  <= (in_side.mode == MODE_FORCE) ^ (!a_ge && !in_bighi);
      s1_sat_r  <= in_bighi || ((mag_w >> 96) != '0);
      s1_zero_r <= in_side.zero;
      s1_kill_r <= (in_side.mode == MODE_NONE) || (well_depth == 32'd0);
      s1_half_r <= (in_side.mode == MODE_ENERGY);
    end
  end

  // Stage 2: partial products of magnitude and well depth. A saturating
  // big power must keep its own sign, so that case keeps the mode's sign.
  logic        s2_vld_r;
  logic [63:0] s2_pp_r [3];
  logic        s2_neg_r;
  logic        s2_sat_r;
  logic        s2_zero_r;
  logic        s2_kill_r;
  logic        s2_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_pp_r[i] <= 64'(s1_mag_r[i*32 +: 32]) * 64'(well_depth);
      end
      s2_neg_r  <= s1_neg_r;
      s2_sat_r  <= s1_sat_r;
      s2_zero_r <= s1_zero_r;
      s2_kill_r <= s1_kill_r;
      s2_half_r <= s1_half_r;
    end
  end

  // Stage 3: sum, shift, saturate into the output register.
  logic [127:0] prod;
  logic [127:0] r_w;
  logic         over;
  out_word_t    word_nxt;

  always_comb begin
    prod = 128'(s2_pp_r[0]) + (128'(s2_pp_r[1]) << 32) + (128'(s2_pp_r[2]) << 64);
    r_w  = s2_half_r ? (prod >> (FRAC_BITS + 1)) : (prod >> FRAC_BITS);
    over = s2_neg_r ? (r_w > {64'd0, 64'h8000_0000_0000_0000})
                    : (r_w > {64'd0, 64'h7FFF_FFFF_FFFF_FFFF});
    if (s2_zero_r) begin
      word_nxt.value  = '0;
      word_nxt.status = ST_ZERO;
    end else if (s2_kill_r) begin
      word_nxt.value  = '0;
      word_nxt.status = ST_OK;
    end else if (s2_sat_r || over) begin
      word_nxt.value  = s2_neg_r ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      word_nxt.status = ST_SAT;
    end else begin
      word_nxt.value  = s2_neg_r ? -r_w[63:0] : r_w[63:0];
      word_nxt.status = ST_OK;
    end
  end

  logic      s3_vld_r;
  out_word_t s3_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_word_r <= word_nxt;
    end
  end

  assign out_vld  = s3_vld_r;
  assign out_word = s3_word_r;

endmodule

### sv/lennard_jones_pair_eval.sv
`timescale 1ns / 1ps
// Top level of the 12-6 Lennard-Jones pair evaluator: configuration registers
// and the divider, power chain and result stages. Depends on ljpe_pkg and submodules.
//
//   Channel   Ports                         Word
//   in        in_valid/in_ready/in_data     distance (Q.F), mode
//   out       out_valid/out_ready/out_data  value (signed Q(64-F).F), status
//   cfg       cfg_psel..cfg_prdata          well_depth at 0x0, length_scale at 0x4
//
// One word enters per cycle while the pipeline is not stalled. The pipeline holds
// 32+FRAC_BITS divider stages (one quotient bit each), two stages for each of the
// thirteen power steps, and three result stages. The whole pipeline moves as one
// when the output register is empty or being taken, so a stall freezes every
// stage and nothing is lost or repeated. Reset clears the valid bits and loads
// both scale registers with 1.0.
module lennard_jones_pair_eval import ljpe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int QW   = 32 + FRAC_BITS;
  localparam int PW   = 66 + FRAC_BITS;
  localparam int NSTP = NUM_POW - 1;

  // Configuration registers. Address bit 2 selects the register.
  logic [31:0] well_depth_r;
  logic [31:0] length_scale_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      well_depth_r   <= 32'h0001_0000;
      length_scale_r <= 32'h0001_0000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2]) begin
        length_scale_r <= cfg_pwdata;
      end else begin
        well_depth_r <= cfg_pwdata;
      end
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? length_scale_r : well_depth_r;

  // The pipeline advances whenever the output register can take a new word.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  side_t in_side;
  assign in_side.mode = in_data.mode;
  assign in_side.zero = (in_data.distance == 32'd0);

  logic          div_vld;
  side_t         div_side;
  logic [QW-1:0] div_q;

  ljpe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .in_side  (in_side),
    .numer_hi (length_scale_r),
    .divisor  (in_data.distance),
    .out_vld  (div_vld),
    .out_side (div_side),
    .quot     (div_q)
  );

  // Power chain p2 .. p14. A step keeps its power when it is one of the two its mode needs.
  logic          c_vld   [NSTP+1];
  side_t         c_side  [NSTP+1];
  logic [QW-1:0] c_q     [NSTP+1];
  logic [PW-1:0] c_p     [NSTP+1];
  logic          c_big   [NSTP+1];
  logic [PW-1:0] c_plo   [NSTP+1];
  logic [PW-1:0] c_phi   [NSTP+1];
  logic          c_bighi [NSTP+1];

  assign c_vld[0]   = div_vld;
  assign c_side[0]  = div_side;
  assign c_q[0]     = div_q;
  assign c_p[0]     = PW'(div_q);
  assign c_big[0]   = 1'b0;
  assign c_plo[0]   = '0;
  assign c_phi[0]   = '0;
  assign c_bighi[0] = 1'b0;

  genvar k;
  generate
    for (k = 0; k < NSTP; k++) begin : g_pow
      ljpe_pow #(.FRAC_BITS(FRAC_BITS), .K(k + 2)) u_pow (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (c_vld[k]),
        .in_side   (c_side[k]),
        .in_q      (c_q[k]),
        .in_p      (c_p[k]),
        .in_big    (c_big[k]),
        .in_plo    (c_plo[k]),
        .in_phi    (c_phi[k]),
        .in_bighi  (c_bighi[k]),
        .out_vld   (c_vld[k+1]),
        .out_side  (c_side[k+1]),
        .out_q     (c_q[k+1]),
        .out_p     (c_p[k+1]),
        .out_big   (c_big[k+1]),
        .out_plo   (c_plo[k+1]),
        .out_phi   (c_phi[k+1]),
        .out_bighi (c_bighi[k+1])
      );
    end
  endgenerate

  ljpe_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .well_depth (well_depth_r),
    .in_vld     (c_vld[NSTP]),
    .in_side    (c_side[NSTP]),
    .in_plo     (c_plo[NSTP]),
    .in_phi     (c_phi[NSTP]),
    .in_bighi   (c_bighi[NSTP]),
    .out_vld    (out_valid),
    .out_word   (out_data)
  );

endmodule
